[hdl/hhd_pkg.sv]
// ----------------------------------------------------------------------------
// hhd_pkg
// Shared types, constants and the static Huffman code table for the decoder.
// ----------------------------------------------------------------------------
package hhd_pkg;

  localparam int unsigned DefMaxCodeBits = 30;
  localparam int unsigned BufW           = 37;
  localparam int unsigned CntW           = 6;
  localparam int unsigned LenW           = 5;
  localparam int unsigned NumCodes       = 257;
  localparam int unsigned EosSym         = 256;

  typedef logic [BufW-1:0] buf_t;
  typedef logic [CntW-1:0] cnt_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // shift in accepted byte
    logic len_start;  // restart length search at length 1
    logic len_step;   // advance to next length
    logic consume;    // drop matched code bits
    logic clear;      // empty buffer and error flag
    logic set_err;    // mark string failed
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;        // current length matches a code
    logic hit_eos;    // match is the end-of-string code
    logic len_over;   // length passed the buffered bits or the max length
    logic cnt_ge_max; // buffered bits reach the max code length
    logic cnt_ge8;    // eight or more bits left
    logic err;        // string failed earlier
  } dp_sts_t;

  // Canonical code: codes are assigned in order of (length, symbol value).
  // Lookup result of the code table: match flag and symbol index.
  typedef struct packed {
    logic       hit;
    logic [8:0] sym;
  } lookup_t;

  function automatic logic [29:0] code_of(input logic [8:0] s);
    logic [29:0] c;
    case (s)
      9'd0: c=30'h1ff8; 9'd1: c=30'h7fffd8; 9'd2: c=30'hfffffe2; 9'd3: c=30'hfffffe3;
      9'd4: c=30'hfffffe4; 9'd5: c=30'hfffffe5; 9'd6: c=30'hfffffe6; 9'd7: c=30'hfffffe7;
      9'd8: c=30'hfffffe8; 9'd9: c=30'hffffea; 9'd10: c=30'h3ffffffc; 9'd11: c=30'hfffffe9;
      9'd12: c=30'hfffffea; 9'd13: c=30'h3ffffffd; 9'd14: c=30'hfffffeb; 9'd15: c=30'hfffffec;
      9'd16: c=30'hfffffed; 9'd17: c=30'hfffffee; 9'd18: c=30'hfffffef; 9'd19: c=30'hffffff0;
      9'd20: c=30'hffffff1; 9'd21: c=30'hffffff2; 9'd22: c=30'h3ffffffe; 9'd23: c=30'hffffff3;
      9'd24: c=30'hffffff4; 9'd25: c=30'hffffff5; 9'd26: c=30'hffffff6; 9'd27: c=30'hffffff7;
      9'd28: c=30'hffffff8; 9'd29: c=30'hffffff9; 9'd30: c=30'hffffffa; 9'd31: c=30'hffffffb;
      9'd32: c=30'h14; 9'd33: c=30'h3f8; 9'd34: c=30'h3f9; 9'd35: c=30'hffa;
      9'd36: c=30'h1ff9; 9'd37: c=30'h15; 9'd38: c=30'hf8; 9'd39: c=30'h7fa;
      9'd40: c=30'h3fa; 9'd41: c=30'h3fb; 9'd42: c=30'hf9; 9'd43: c=30'h7fb;
      9'd44: c=30'hfa; 9'd45: c=30'h16; 9'd46: c=30'h17; 9'd47: c=30'h18;
      9'd48: c=30'h0; 9'd49: c=30'h1; 9'd50: c=30'h2; 9'd51: c=30'h19;
      9'd52: c=30'h1a; 9'd53: c=30'h1b; 9'd54: c=30'h1c; 9'd55: c=30'h1d;
      9'd56: c=30'h1e; 9'd57: c=30'h1f; 9'd58: c=30'h5c; 9'd59: c=30'hfb;
      9'd60: c=30'h7ffc; 9'd61: c=30'h20; 9'd62: c=30'hffb; 9'd63: c=30'h3fc;
      9'd64: c=30'h1ffa; 9'd65: c=30'h21; 9'd66: c=30'h5d; 9'd67: c=30'h5e;
      9'd68: c=30'h5f; 9'd69: c=30'h60; 9'd70: c=30'h61; 9'd71: c=30'h62;
      9'd72: c=30'h63; 9'd73: c=30'h64; 9'd74: c=30'h65; 9'd75: c=30'h66;
      9'd76: c=30'h67; 9'd77: c=30'h68; 9'd78: c=30'h69; 9'd79: c=30'h6a;
      9'd80: c=30'h6b; 9'd81: c=30'h6c; 9'd82: c=30'h6d; 9'd83: c=30'h6e;
      9'd84: c=30'h6f; 9'd85: c=30'h70; 9'd86: c=30'h71; 9'd87: c=30'h72;
      9'd88: c=30'hfc; 9'd89: c=30'h73; 9'd90: c=30'hfd; 9'd91: c=30'h1ffb;
      9'd92: c=30'h7fff0; 9'd93: c=30'h1ffc; 9'd94: c=30'h3ffc; 9'd95: c=30'h22;
      9'd96: c=30'h7ffd; 9'd97: c=30'h3; 9'd98: c=30'h23; 9'd99: c=30'h4;
      9'd100: c=30'h24; 9'd101: c=30'h5; 9'd102: c=30'h25; 9'd103: c=30'h26;
      9'd104: c=30'h27; 9'd105: c=30'h6; 9'd106: c=30'h74; 9'd107: c=30'h75;
      9'd108: c=30'h28; 9'd109: c=30'h29; 9'd110: c=30'h2a; 9'd111: c=30'h7;
      9'd112: c=30'h2b; 9'd113: c=30'h76; 9'd114: c=30'h2c; 9'd115: c=30'h8;
      9'd116: c=30'h9; 9'd117: c=30'h2d; 9'd118: c=30'h77; 9'd119: c=30'h78;
      9'd120: c=30'h79; 9'd121: c=30'h7a; 9'd122: c=30'h7b; 9'd123: c=30'h7ffe;
      9'd124: c=30'h7fc; 9'd125: c=30'h3ffd; 9'd126: c=30'h1ffd; 9'd127: c=30'hffffffc;
      9'd128: c=30'hfffe6; 9'd129: c=30'h3fffd2; 9'd130: c=30'hfffe7; 9'd131: c=30'hfffe8;
      9'd132: c=30'h3fffd3; 9'd133: c=30'h3fffd4; 9'd134: c=30'h3fffd5; 9'd135: c=30'h7fffd9;
      9'd136: c=30'h3fffd6; 9'd137: c=30'h7fffda; 9'd138: c=30'h7fffdb; 9'd139: c=30'h7fffdc;
      9'd140: c=30'h7fffdd; 9'd141: c=30'h7fffde; 9'd142: c=30'hffffeb; 9'd143: c=30'h7fffdf;
      9'd144: c=30'hffffec; 9'd145: c=30'hffffed; 9'd146: c=30'h3fffd7; 9'd147: c=30'h7fffe0;
      9'd148: c=30'hffffee; 9'd149: c=30'h7fffe1; 9'd150: c=30'h7fffe2; 9'd151: c=30'h7fffe3;
      9'd152: c=30'h7fffe4; 9'd153: c=30'h1fffdc; 9'd154: c=30'h3fffd8; 9'd155: c=30'h7fffe5;
      9'd156: c=30'h3fffd9; 9'd157: c=30'h7fffe6; 9'd158: c=30'h7fffe7; 9'd159: c=30'hffffef;
      9'd160: c=30'h3fffda; 9'd161: c=30'h1fffdd; 9'd162: c=30'hfffe9; 9'd163: c=30'h3fffdb;
      9'd164: c=30'h3fffdc; 9'd165: c=30'h7fffe8; 9'd166: c=30'h7fffe9; 9'd167: c=30'h1fffde;
      9'd168: c=30'h7fffea; 9'd169: c=30'h3fffdd; 9'd170: c=30'h3fffde; 9'd171: c=30'hfffff0;
      9'd172: c=30'h1fffdf; 9'd173: c=30'h3fffdf; 9'd174: c=30'h7fffeb; 9'd175: c=30'h7fffec;
      9'd176: c=30'h1fffe0; 9'd177: c=30'h1fffe1; 9'd178: c=30'h3fffe0; 9'd179: c=30'h1fffe2;
      9'd180: c=30'h7fffed; 9'd181: c=30'h3fffe1; 9'd182: c=30'h7fffee; 9'd183: c=30'h7fffef;
      9'd184: c=30'hfffea; 9'd185: c=30'h3fffe2; 9'd186: c=30'h3fffe3; 9'd187: c=30'h3fffe4;
      9'd188: c=30'h7ffff0; 9'd189: c=30'h3fffe5; 9'd190: c=30'h3fffe6; 9'd191: c=30'h7ffff1;
      9'd192: c=30'h3ffffe0; 9'd193: c=30'h3ffffe1; 9'd194: c=30'hfffeb; 9'd195: c=30'h7fff1;
      9'd196: c=30'h3fffe7; 9'd197: c=30'h7ffff2; 9'd198: c=30'h3fffe8; 9'd199: c=30'h1ffffec;
      9'd200: c=30'h3ffffe2; 9'd201: c=30'h3ffffe3; 9'd202: c=30'h3ffffe4; 9'd203: c=30'h7ffffde;
      9'd204: c=30'h7ffffdf; 9'd205: c=30'h3ffffe5; 9'd206: c=30'hfffff1; 9'd207: c=30'h1ffffed;
      9'd208: c=30'h7fff2; 9'd209: c=30'h1fffe3; 9'd210: c=30'h3ffffe6; 9'd211: c=30'h7ffffe0;
      9'd212: c=30'h7ffffe1; 9'd213: c=30'h3ffffe7; 9'd214: c=30'h7ffffe2; 9'd215: c=30'hfffff2;
      9'd216: c=30'h1fffe4; 9'd217: c=30'h1fffe5; 9'd218: c=30'h3ffffe8; 9'd219: c=30'h3ffffe9;
      9'd220: c=30'hffffffd; 9'd221: c=30'h7ffffe3; 9'd222: c=30'h7ffffe4; 9'd223: c=30'h7ffffe5;
      9'd224: c=30'hfffec; 9'd225: c=30'hfffff3; 9'd226: c=30'hfffed; 9'd227: c=30'h1fffe6;
      9'd228: c=30'h3fffe9; 9'd229: c=30'h1fffe7; 9'd230: c=30'h1fffe8; 9'd231: c=30'h7ffff3;
      9'd232: c=30'h3fffea; 9'd233: c=30'h3fffeb; 9'd234: c=30'h1ffffee; 9'd235: c=30'h1ffffef;
      9'd236: c=30'hfffff4; 9'd237: c=30'hfffff5; 9'd238: c=30'h3ffffea; 9'd239: c=30'h7ffff4;
      9'd240: c=30'h3ffffeb; 9'd241: c=30'h7ffffe6; 9'd242: c=30'h3ffffec; 9'd243: c=30'h3ffffed;
      9'd244: c=30'h7ffffe7; 9'd245: c=30'h7ffffe8; 9'd246: c=30'h7ffffe9; 9'd247: c=30'h7ffffea;
      9'd248: c=30'h7ffffeb; 9'd249: c=30'hffffffe; 9'd250: c=30'h7ffffec; 9'd251: c=30'h7ffffed;
      9'd252: c=30'h7ffffee; 9'd253: c=30'h7ffffef; 9'd254: c=30'h7fffff0; 9'd255: c=30'h3ffffee;
      default: c=30'h3fffffff;
    endcase
    return c;
  endfunction

  function automatic logic [LenW-1:0] len_of(input logic [8:0] s);
    logic [LenW-1:0] l;
    case (s)
      9'd0: l=5'd13; 9'd1: l=5'd23; 9'd2,9'd3,9'd4,9'd5,9'd6,9'd7,9'd8: l=5'd28;
      9'd9: l=5'd24; 9'd10: l=5'd30; 9'd11,9'd12: l=5'd28; 9'd13: l=5'd30;
      9'd14,9'd15,9'd16,9'd17,9'd18,9'd19,9'd20,9'd21: l=5'd28; 9'd22: l=5'd30;
      9'd23,9'd24,9'd25,9'd26,9'd27,9'd28,9'd29,9'd30,9'd31: l=5'd28;
      9'd32: l=5'd6; 9'd33,9'd34: l=5'd10; 9'd35: l=5'd12; 9'd36: l=5'd13; 9'd37: l=5'd6;
      9'd38: l=5'd8; 9'd39: l=5'd11; 9'd40,9'd41: l=5'd10; 9'd42: l=5'd8; 9'd43: l=5'd11;
      9'd44: l=5'd8; 9'd45,9'd46,9'd47: l=5'd6; 9'd48,9'd49,9'd50: l=5'd5;
      9'd51,9'd52,9'd53,9'd54,9'd55,9'd56,9'd57: l=5'd6; 9'd58: l=5'd7; 9'd59: l=5'd8;
      9'd60: l=5'd15; 9'd61: l=5'd6; 9'd62: l=5'd12; 9'd63: l=5'd10; 9'd64: l=5'd13;
      9'd65: l=5'd6; 9'd88: l=5'd8; 9'd90: l=5'd8; 9'd91: l=5'd13; 9'd92: l=5'd19;
      9'd93: l=5'd13; 9'd94: l=5'd14; 9'd95: l=5'd6; 9'd96: l=5'd15; 9'd97: l=5'd5;
      9'd98: l=5'd6; 9'd99: l=5'd5; 9'd100: l=5'd6; 9'd101: l=5'd5;
      9'd102,9'd103,9'd104: l=5'd6; 9'd105: l=5'd5; 9'd106,9'd107: l=5'd7;
      9'd108,9'd109,9'd110: l=5'd6; 9'd111: l=5'd5; 9'd112: l=5'd6; 9'd113: l=5'd7;
      9'd114: l=5'd6; 9'd115,9'd116: l=5'd5; 9'd117: l=5'd6;
      9'd118,9'd119,9'd120,9'd121,9'd122: l=5'd7; 9'd123: l=5'd15; 9'd124: l=5'd11;
      9'd125: l=5'd14; 9'd126: l=5'd13; 9'd127: l=5'd28;
      9'd128: l=5'd20; 9'd129: l=5'd22; 9'd130,9'd131: l=5'd20;
      9'd132,9'd133,9'd134: l=5'd22; 9'd135: l=5'd23; 9'd136: l=5'd22;
      9'd137,9'd138,9'd139,9'd140,9'd141: l=5'd23; 9'd142: l=5'd24; 9'd143: l=5'd23;
      9'd144,9'd145: l=5'd24; 9'd146: l=5'd22; 9'd147: l=5'd23; 9'd148: l=5'd24;
      9'd149,9'd150,9'd151,9'd152: l=5'd23; 9'd153: l=5'd21; 9'd154: l=5'd22;
      9'd155: l=5'd23; 9'd156: l=5'd22; 9'd157,9'd158: l=5'd23; 9'd159: l=5'd24;
      9'd160: l=5'd22; 9'd161: l=5'd21; 9'd162: l=5'd20; 9'd163,9'd164: l=5'd22;
      9'd165,9'd166: l=5'd23; 9'd167: l=5'd21; 9'd168: l=5'd23; 9'd169,9'd170: l=5'd22;
      9'd171: l=5'd24; 9'd172: l=5'd21; 9'd173: l=5'd22; 9'd174,9'd175: l=5'd23;
      9'd176,9'd177: l=5'd21; 9'd178: l=5'd22; 9'd179: l=5'd21; 9'd180: l=5'd23;
      9'd181: l=5'd22; 9'd182,9'd183: l=5'd23; 9'd184: l=5'd20;
      9'd185,9'd186,9'd187: l=5'd22; 9'd188: l=5'd23; 9'd189,9'd190: l=5'd22;
      9'd191: l=5'd23; 9'd192,9'd193: l=5'd26; 9'd194: l=5'd20; 9'd195: l=5'd19;
      9'd196: l=5'd22; 9'd197: l=5'd23; 9'd198: l=5'd22; 9'd199: l=5'd25;
      9'd200,9'd201,9'd202: l=5'd26; 9'd203,9'd204: l=5'd27; 9'd205: l=5'd26;
      9'd206: l=5'd24; 9'd207: l=5'd25; 9'd208: l=5'd19; 9'd209: l=5'd21;
      9'd210: l=5'd26; 9'd211,9'd212: l=5'd27; 9'd213: l=5'd26; 9'd214: l=5'd27;
      9'd215: l=5'd24; 9'd216,9'd217: l=5'd21; 9'd218,9'd219: l=5'd26; 9'd220: l=5'd28;
      9'd221,9'd222,9'd223: l=5'd27; 9'd224: l=5'd20; 9'd225: l=5'd24; 9'd226: l=5'd20;
      9'd227: l=5'd21; 9'd228: l=5'd22; 9'd229,9'd230: l=5'd21; 9'd231: l=5'd23;
      9'd232,9'd233: l=5'd22; 9'd234,9'd235: l=5'd25; 9'd236,9'd237: l=5'd24;
      9'd238: l=5'd26; 9'd239: l=5'd23; 9'd240: l=5'd26; 9'd241: l=5'd27;
      9'd242,9'd243: l=5'd26; 9'd244,9'd245,9'd246,9'd247,9'd248: l=5'd27;
      9'd249: l=5'd28; 9'd250,9'd251,9'd252,9'd253,9'd254: l=5'd27; 9'd255: l=5'd26;
      9'd256: l=5'd30;
      default: l=5'd7; // 66..87, 89
    endcase
    return l;
  endfunction

endpackage

[hdl/hpack_huffman_decoder.sv]
// ----------------------------------------------------------------------------
// hpack_huffman_decoder
// HPACK static Huffman string decoder, one encoded byte per request.
// ----------------------------------------------------------------------------
// Input channel: data_byte_i/last_byte_i under in_valid_i/in_stall_o.
// Output channel: one result per request under out_valid_o/out_stall_i:
// decoded symbols, an error result, and a closing result after a byte
// marked last. last_of_run_o flags the final result caused by one byte.
// A byte is taken only while the sequencer is idle; a byte that arrives
// after an error and is not last is dropped with no search. Otherwise
// the search runs one code length per cycle, from length 1 upward, but
// waits while a result is due and the output register is stalled.
// Each found code is consumed and the search restarts at length 1. The
// search that finds no further code ends when the length passes the bits
// left or MaxCodeBits. Errors and closing results have their own states.
// A symbol is held until the next search outcome sets its last_of_run flag,
// then shows on the port from the output register in the next cycle.
// Reset clears the bit buffer, count, error flag and output register.
// While the receiver stalls, the result holds; a further result waits.
// ----------------------------------------------------------------------------
module hpack_huffman_decoder #(
  parameter int unsigned MaxCodeBits = hhd_pkg::DefMaxCodeBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] symbol_o,
  output logic       symbol_valid_o,
  output logic       decode_error_o,
  output logic       string_done_o,
  output logic       last_of_run_o
);

  hhd_pkg::dp_cmd_t cmd;
  hhd_pkg::dp_sts_t sts;
  logic             sym_out;

  hhd_datapath #(.MaxCodeBits(MaxCodeBits)) u_dp (
    .clk_i, .rst_ni, .byte_i(data_byte_i), .cmd_i(cmd), .sym_out_i(sym_out),
    .sts_o(sts), .sym_o(symbol_o)
  );

  hhd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .last_i(last_byte_i),
    .out_valid_o, .out_stall_i, .sym_out_o(sym_out),
    .o_sv_o(symbol_valid_o), .o_err_o(decode_error_o), .o_done_o(string_done_o),
    .o_last_o(last_of_run_o), .sts_i(sts), .cmd_o(cmd)
  );

endmodule

[hdl/hhd_match.sv]
// ----------------------------------------------------------------------------
// hhd_match
// Code table lookup: finds the symbol whose code of a given length equals
// the given top bits of the buffer. Constant table compared in parallel.
// ----------------------------------------------------------------------------
module hhd_match (
  input  logic [29:0]              bits_i,
  input  logic [hhd_pkg::LenW-1:0] len_i,
  output hhd_pkg::lookup_t         res_o
);

  always_comb begin
    res_o = '0;
    for (int s = hhd_pkg::NumCodes - 1; s >= 0; s--) begin
      if (hhd_pkg::len_of(9'(s)) == len_i && hhd_pkg::code_of(9'(s)) == bits_i) begin
        res_o.hit = 1'b1;
        res_o.sym = 9'(s);
      end
    end
  end

endmodule

[hdl/hhd_datapath.sv]
// ----------------------------------------------------------------------------
// hhd_datapath
// Bit buffer, bit count, length search register, error flag and the
// pending and output symbol registers.
// ----------------------------------------------------------------------------
module hhd_datapath #(
  parameter int unsigned MaxCodeBits = hhd_pkg::DefMaxCodeBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       byte_i,
  input  hhd_pkg::dp_cmd_t cmd_i,
  input  logic             sym_out_i,
  output hhd_pkg::dp_sts_t sts_o,
  output logic [7:0]       sym_o
);

  localparam int unsigned LW = $clog2(MaxCodeBits + 2);

  hhd_pkg::buf_t    buf_q, buf_d;
  hhd_pkg::cnt_t    cnt_q, cnt_d;
  logic [LW-1:0]    len_q, len_d;
  logic             err_q, err_d;
  logic [7:0]       psym_q, psym_d;
  logic [7:0]       osym_q, osym_d;
  logic [29:0]      top;
  logic [hhd_pkg::LenW-1:0] len5;
  hhd_pkg::lookup_t lk;
  hhd_pkg::buf_t    mask;

  always_comb begin
    top = 30'((buf_q >> (cnt_q - hhd_pkg::cnt_t'(len_q))) &
              ((hhd_pkg::buf_t'(1) << len_q) - hhd_pkg::buf_t'(1)));
  end

  // lengths above 31 never match a table entry
  assign len5 = (len_q > LW'(31)) ? '0 : hhd_pkg::LenW'(len_q);

  hhd_match u_match (.bits_i(top), .len_i(len5), .res_o(lk));

  assign sts_o.hit        = lk.hit && (len_q != '0);
  assign sts_o.hit_eos    = lk.sym == 9'(hhd_pkg::EosSym);
  assign sts_o.len_over   = (32'(len_q) > MaxCodeBits) || (32'(len_q) > 32'(cnt_q));
  assign sts_o.cnt_ge_max = 32'(cnt_q) >= MaxCodeBits;
  assign sts_o.cnt_ge8    = cnt_q >= hhd_pkg::cnt_t'(8);
  assign sts_o.err        = err_q;
  assign sym_o            = osym_q;

  always_comb begin
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    len_d  = len_q;
    err_d  = err_q;
    psym_d = psym_q;
    osym_d = osym_q;
    mask  = (hhd_pkg::buf_t'(1) << (cnt_q - hhd_pkg::cnt_t'(len_q))) - hhd_pkg::buf_t'(1);
    if (cmd_i.load) begin
      buf_d = {buf_q[hhd_pkg::BufW-9:0], byte_i};
      cnt_d = cnt_q + hhd_pkg::cnt_t'(8);
    end
    if (cmd_i.consume) begin
      buf_d  = buf_q & mask;
      cnt_d  = cnt_q - hhd_pkg::cnt_t'(len_q);
      psym_d = lk.sym[7:0];
    end
    // error and closing results carry a zero symbol
    if (sym_out_i) osym_d = psym_q;
    else if (cmd_i.clear) osym_d = '0;
    if (cmd_i.len_start) len_d = LW'(1);
    else if (cmd_i.len_step) len_d = len_q + LW'(1);
    if (cmd_i.set_err) err_d = 1'b1;
    if (cmd_i.clear) begin
      buf_d = '0;
      cnt_d = '0;
      if (!cmd_i.set_err) err_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      cnt_q  <= '0;
      len_q  <= LW'(1);
      err_q  <= 1'b0;
      psym_q <= '0;
      osym_q <= '0;
    end else begin
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
      len_q  <= len_d;
      err_q  <= err_d;
      psym_q <= psym_d;
      osym_q <= osym_d;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= hhd_pkg::cnt_t'(hhd_pkg::BufW)) else $error("bit count overflow");
  a_err_clears_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_err |=> cnt_q == '0) else $error("buffer not cleared on error");
  a_consume_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.consume |-> sts_o.hit) else $error("consume without match");
`endif

endmodule

[hdl/hhd_ctrl.sv]
// ----------------------------------------------------------------------------
// hhd_ctrl
// Sequencer: accepts a byte, steps the length search, and issues results.
// ----------------------------------------------------------------------------
module hhd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             sym_out_o,
  output logic             o_sv_o,
  output logic             o_err_o,
  output logic             o_done_o,
  output logic             o_last_o,
  input  hhd_pkg::dp_sts_t sts_i,
  output hhd_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StSearch = 4'b0010,
    StErr    = 4'b0100,
    StClose  = 4'b1000
  } state_e;

  state_e st_q, st_d;
  logic   last_q, last_d;
  logic   pend_q, pend_d;  // decoded symbol waiting in the datapath
  logic   ov_q, ov_d;      // output register full
  logic   sv_q, sv_d, er_q, er_d, dn_q, dn_d, lr_q, lr_d;
  logic   free;

  assign free        = !ov_q || !out_stall_i;
  assign out_valid_o = ov_q;
  assign in_stall_o  = (st_q != StIdle);
  assign o_sv_o = sv_q;
  assign o_err_o = er_q;
  assign o_done_o = dn_q;
  assign o_last_o = lr_q;

  always_comb begin
    st_d = st_q; last_d = last_q; pend_d = pend_q;
    ov_d = ov_q && out_stall_i;
    sv_d = sv_q; er_d = er_q; dn_d = dn_q; lr_d = lr_q;
    cmd_o = '0;
    sym_out_o = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          last_d = last_i;
          cmd_o.len_start = 1'b1;
          if (sts_i.err) begin
            st_d = last_i ? StClose : StIdle;
          end else begin
            cmd_o.load = 1'b1;
            st_d = StSearch;
          end
        end
      end
      StSearch: begin
        if (sts_i.len_over) begin
          if (sts_i.cnt_ge_max || (last_q && sts_i.cnt_ge8)) st_d = StErr;
          else if (last_q) st_d = StClose;
          else if (!pend_q) st_d = StIdle;
          else if (free) begin
            // nothing else comes from this byte: the held symbol ends the run
            ov_d = 1'b1; sv_d = 1'b1; er_d = 1'b0; dn_d = 1'b0; lr_d = 1'b1;
            sym_out_o = 1'b1;
            pend_d = 1'b0;
            st_d = StIdle;
          end
        end else if (sts_i.hit) begin
          if (sts_i.hit_eos) st_d = StErr;
          else if (!pend_q || free) begin
            // a further symbol is found; a held one, if any, is issued now
            if (pend_q) begin
              ov_d = 1'b1; sv_d = 1'b1; er_d = 1'b0; dn_d = 1'b0; lr_d = 1'b0;
              sym_out_o = 1'b1;
            end
            cmd_o.consume = 1'b1;
            cmd_o.len_start = 1'b1;
            pend_d = 1'b1;
          end
        end else begin
          cmd_o.len_step = 1'b1;
        end
      end
      StErr: begin
        if (free) begin
          if (pend_q) begin
            ov_d = 1'b1; sv_d = 1'b1; er_d = 1'b0; dn_d = 1'b0; lr_d = 1'b0;
            sym_out_o = 1'b1;
            pend_d = 1'b0;
          end else begin
            ov_d = 1'b1; sv_d = 1'b0; er_d = 1'b1; dn_d = 1'b0; lr_d = !last_q;
            cmd_o.set_err = 1'b1;
            cmd_o.clear = 1'b1;
            st_d = last_q ? StClose : StIdle;
          end
        end
      end
      StClose: begin
        if (free) begin
          if (pend_q) begin
            ov_d = 1'b1; sv_d = 1'b1; er_d = 1'b0; dn_d = 1'b0; lr_d = 1'b0;
            sym_out_o = 1'b1;
            pend_d = 1'b0;
          end else begin
            ov_d = 1'b1; sv_d = 1'b0; er_d = sts_i.err; dn_d = 1'b1; lr_d = 1'b1;
            cmd_o.clear = 1'b1;
            st_d = StIdle;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; last_q <= 1'b0; pend_q <= 1'b0; ov_q <= 1'b0;
      sv_q <= 1'b0; er_q <= 1'b0; dn_q <= 1'b0; lr_q <= 1'b0;
    end else begin
      st_q <= st_d; last_q <= last_d; pend_q <= pend_d; ov_q <= ov_d;
      sv_q <= sv_d; er_q <= er_d; dn_q <= dn_d; lr_q <= lr_d;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q) else $error("result dropped");
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && dn_q) |-> lr_q) else $error("closing result not last of run");
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> st_q == StIdle) else $error("accept outside idle");
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StIdle |-> !pend_q) else $error("symbol left behind");
`endif

endmodule

[bench/hhd_checker.sv]
// ----------------------------------------------------------------------------
// hhd_checker
// Watches both channels of the Huffman decoder, predicts each request's
// results from its own copy of the bit buffer and compares them in order.
// ----------------------------------------------------------------------------
module hhd_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] symbol_i,
  input  logic       symbol_valid_i,
  input  logic       decode_error_i,
  input  logic       string_done_i,
  input  logic       last_of_run_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxLen = hhd_pkg::DefMaxCodeBits;
  localparam int Eos    = hhd_pkg::EosSym;

  typedef struct packed {
    logic [7:0] sym;
    logic       sym_ok;
    logic       err;
    logic       done;
    logic       lor;
  } dec_res_t;

  // code lengths of the static table; codes are canonical and built below
  int sym_len [hhd_pkg::NumCodes] = '{
    13,23,28,28,28,28,28,28, 28,24,30,28,28,30,28,28,
    28,28,28,28,28,28,30,28, 28,28,28,28,28,28,28,28,
    6,10,10,12,13,6,8,11, 10,10,8,11,8,6,6,6,
    5,5,5,6,6,6,6,6, 6,6,7,8,15,6,12,10,
    13,6,7,7,7,7,7,7, 7,7,7,7,7,7,7,7,
    7,7,7,7,7,7,7,7, 8,7,8,13,19,13,14,6,
    15,5,6,5,6,5,6,6, 6,5,7,7,6,6,6,5,
    6,7,6,5,5,6,7,7, 7,7,7,15,11,14,13,28,
    20,22,20,20,22,22,22,23, 22,23,23,23,23,23,24,23,
    24,24,22,23,24,23,23,23, 23,21,22,23,22,23,23,24,
    22,21,20,22,22,23,23,21, 23,22,22,24,21,22,23,23,
    21,21,22,21,23,22,23,23, 20,22,22,22,23,22,22,23,
    26,26,20,19,22,23,22,25, 26,26,26,27,27,26,24,25,
    19,21,26,27,27,26,27,24, 21,21,26,26,28,27,27,27,
    20,24,20,21,22,21,21,23, 22,22,25,25,24,24,26,23,
    26,27,26,26,27,27,27,27, 27,28,27,27,27,27,27,26,
    30};
  logic [29:0] sym_code [hhd_pkg::NumCodes];

  logic [36:0] bit_acc;
  int          bit_cnt;
  logic        str_failed;
  dec_res_t    expected_q[$];
  int          fails = 0;

  initial begin
    logic [29:0] c;
    c = '0;
    for (int l = 1; l <= MaxLen; l++) begin
      for (int s = 0; s < hhd_pkg::NumCodes; s++) begin
        if (sym_len[s] == l) begin
          sym_code[s] = c;
          c++;
        end
      end
      c = c << 1;
    end
  end

  function automatic dec_res_t mk(logic [7:0] s, logic v, logic e, logic d);
    dec_res_t r;
    r = '{sym: s, sym_ok: v, err: e, done: d, lor: 1'b0};
    return r;
  endfunction

  function automatic void queue_exp(dec_res_t r);
    expected_q = {expected_q, r};
  endfunction

  // shortest-first search over the buffered bits; -1 when nothing matches
  function automatic int find_code(output int used);
    logic [36:0] top;
    used = 0;
    for (int l = 1; l <= MaxLen && l <= bit_cnt; l++) begin
      top = (bit_acc >> (bit_cnt - l)) & ((37'd1 << l) - 1);
      for (int s = 0; s < hhd_pkg::NumCodes; s++) begin
        if (sym_len[s] == l && 37'(sym_code[s]) == top) begin
          used = l;
          return s;
        end
      end
    end
    return -1;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic last);
    int n;
    int s;
    int used;
    logic bad;
    n = 0;
    bad = 1'b0;
    if (!str_failed) begin
      bit_acc = {bit_acc[28:0], b};
      bit_cnt += 8;
      forever begin
        s = find_code(used);
        if (s < 0) begin
          if (bit_cnt >= MaxLen) bad = 1'b1;
          break;
        end
        if (s == Eos) begin
          bad = 1'b1;
          break;
        end
        bit_cnt -= used;
        bit_acc &= (37'd1 << bit_cnt) - 1;
        queue_exp(mk(s[7:0], 1'b1, 1'b0, 1'b0));
        n++;
      end
      if (bad) begin
        str_failed = 1'b1;
        bit_acc = '0;
        bit_cnt = 0;
        queue_exp(mk(8'd0, 1'b0, 1'b1, 1'b0));
        n++;
      end
    end
    if (last) begin
      if (!str_failed && bit_cnt >= 8) begin
        str_failed = 1'b1;
        queue_exp(mk(8'd0, 1'b0, 1'b1, 1'b0));
        n++;
      end
      queue_exp(mk(8'd0, 1'b0, str_failed, 1'b1));
      n++;
      bit_acc = '0;
      bit_cnt = 0;
      str_failed = 1'b0;
    end
    if (n > 0) expected_q[$].lor = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dec_res_t got;
    dec_res_t want;
    if (!rst_ni) begin
      bit_acc = '0;
      bit_cnt = 0;
      str_failed = 1'b0;
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) decode_byte(data_byte_i, last_byte_i);
      if (out_valid_i && !out_stall_i) begin
        got = '{sym: symbol_i, sym_ok: symbol_valid_i, err: decode_error_i,
                done: string_done_i, lor: last_of_run_i};
        if (expected_q.size() == 0) begin
          $display("%0t: result exp none got %h", $time, got);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (got.sym !== want.sym) begin
            $display("%0t: symbol exp %h got %h", $time, want.sym, got.sym);
            fails++;
          end
          if (got.sym_ok !== want.sym_ok) begin
            $display("%0t: symbol_valid exp %b got %b", $time, want.sym_ok, got.sym_ok);
            fails++;
          end
          if (got.err !== want.err) begin
            $display("%0t: decode_error exp %b got %b", $time, want.err, got.err);
            fails++;
          end
          if (got.done !== want.done) begin
            $display("%0t: string_done exp %b got %b", $time, want.done, got.done);
            fails++;
          end
          if (got.lor !== want.lor) begin
            $display("%0t: last_of_run exp %b got %b", $time, want.lor, got.lor);
            fails++;
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

  assign fail_count_o = fails;

endmodule

[bench/tb_hpack_huffman_decoder.sv]
// ----------------------------------------------------------------------------
// tb_hpack_huffman_decoder
// Sends Huffman-coded strings (well formed, with bad codes, bad padding and
// noise) to the decoder under random idling; the checker judges the results.
// ----------------------------------------------------------------------------
module tb_hpack_huffman_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Eos = hhd_pkg::EosSym;
  localparam int IdleLimit = 5000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = '0;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] symbol_o;
  logic       symbol_valid_o, decode_error_o, string_done_o, last_of_run_o;
  int         fail_count, pending;
  int         bytes_sent = 0;
  bit         quiet = 1'b0;
  int         idle_cycles = 0;
  int         out_burst = 0;

  hpack_huffman_decoder dut (.*);

  hhd_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .data_byte_i,
    .last_byte_i, .out_valid_i(out_valid_o), .out_stall_i, .symbol_i(symbol_o),
    .symbol_valid_i(symbol_valid_o), .decode_error_i(decode_error_o),
    .string_done_i(string_done_o), .last_of_run_i(last_of_run_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #2 clk_i = ~clk_i;

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (out_burst > 0) begin
      out_burst <= out_burst - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      out_burst <= $urandom_range(1, 12);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  // pad: 0 ones, 1 random bits, 2 ones plus a whole extra byte of ones
  task automatic send_string(input int syms[$], input int pad);
    bit bits[$];
    logic [7:0] b;
    foreach (syms[i])
      for (int k = chk.sym_len[syms[i]] - 1; k >= 0; k--)
        bits = {bits, chk.sym_code[syms[i]][k]};
    while (bits.size() % 8 != 0)
      bits = {bits, (pad == 1) ? 1'($urandom_range(0, 1)) : 1'b1};
    if (pad == 2) repeat (8) bits = {bits, 1'b1};
    if (bits.size() == 0) repeat (8) bits = {bits, 1'b1};
    for (int i = 0; i < bits.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7-k] = bits[i+k];
      send_byte(b, i + 8 >= bits.size());
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
  endtask

  initial begin
    int syms[$];
    int r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: table extremes, several codes per byte, end-of-string code in
    // data, long padding, error state with ignored bytes, unchecked padding
    send_string('{0}, 0);
    send_string('{255}, 0);
    send_string('{48, 48, 49, 50, 97}, 0);
    send_string('{10, 13, 22}, 0);
    send_string('{97, Eos, 98}, 0);
    send_string('{97}, 2);
    send_byte(8'hff, 1'b1);
    for (int i = 0; i < 4; i++) send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5a, 1'b1);
    send_string('{101, 116}, 1);
    send_byte(8'h00, 1'b1);

    // let the decoder drain before the random part
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);

    while (bytes_sent < 310) begin
      if (bytes_sent > 270) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_noise();
      end else begin
        syms.delete();
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 19))
            0:       syms = {syms, Eos};
            1, 2, 3: syms = {syms, int'($urandom_range(0, 255))};
            default: syms = {syms, int'($urandom_range(32, 126))};
          endcase
        end
        r = $urandom_range(0, 9);
        send_string(syms, r == 0 ? 2 : (r < 3 ? 1 : 0));
      end
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
